// ===== src/upsample_gradient_block_sum_top_defines.svh =====
// Assertion macros for the top-level RTL.
`ifndef UPSAMPLE_GRADIENT_BLOCK_SUM_TOP_DEFINES_SVH
`define UPSAMPLE_GRADIENT_BLOCK_SUM_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define UGBS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define UGBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ugbs_pkg.sv =====
`default_nettype none
package ugbs_pkg;

  localparam int DEF_MAX_SRC_WIDTH = 512;
  localparam int DEF_MAX_SCALE     = 8;
  localparam int DEF_GRAD_WIDTH    = 32;

  // Accumulator headroom over the gradient width
  localparam int ACC_HEADROOM = 6;

  localparam int MAX_SRC_HEIGHT = 512;
  localparam int MAX_CHANNELS   = 1024;
  localparam int MAX_BATCH      = 64;

  localparam int ROW_BITS   = 9;
  localparam int CHAN_BITS  = 10;
  localparam int BATCH_BITS = 6;

  localparam int SCALE_REG_BITS  = 4;
  localparam int WIDTH_REG_BITS  = 10;
  localparam int HEIGHT_REG_BITS = 10;
  localparam int CHAN_REG_BITS   = 11;
  localparam int BATCH_REG_BITS  = 7;

  localparam logic [SCALE_REG_BITS-1:0]  SCALE_RESET  = 4'd2;
  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 10'd13;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 10'd13;
  localparam logic [CHAN_REG_BITS-1:0]   CHAN_RESET   = 11'd256;
  localparam logic [BATCH_REG_BITS-1:0]  BATCH_RESET  = 7'd1;

  localparam int COL_OUT_BITS  = 9;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [2:0] {
    REG_SCALE  = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_CHAN   = 3'd3,
    REG_BATCH  = 3'd4
  } reg_idx_t;

  // Position flags of the word being accepted
  typedef struct packed {
    logic first;        // first element of a block
    logic last;         // last element of a block
    logic row_done;     // last source column of the row
    logic tensor_done;  // last block of the tensor
  } pos_flags_t;

  // Zero acts as one, anything above hi is capped
  function automatic logic [31:0] clamp_limit(input logic [31:0] raw, input logic [31:0] hi);
    logic [31:0] res;
    if (raw == 32'd0) begin
      res = 32'd1;
    end else if (raw > hi) begin
      res = hi;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== src/ugbs_if.sv =====
`default_nettype none
interface ugbs_in_if
  import ugbs_pkg::*;
#(
  parameter int GRAD_WIDTH = DEF_GRAD_WIDTH
) ();
  logic                         valid;
  logic                         ready;
  logic signed [GRAD_WIDTH-1:0] dst_gradient;
  logic signed [GRAD_WIDTH-1:0] prior_src_gradient;

  modport source (output valid, dst_gradient, prior_src_gradient, input ready);
  modport sink   (input valid, dst_gradient, prior_src_gradient, output ready);
endinterface

interface ugbs_out_if
  import ugbs_pkg::*;
#(
  parameter int GRAD_WIDTH = DEF_GRAD_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [GRAD_WIDTH-1:0]  src_gradient;
  logic [COL_OUT_BITS-1:0]       src_column;
  logic                          row_done;
  logic                          tensor_done;
  logic                          saturated;

  modport source (output valid, src_gradient, src_column, row_done, tensor_done, saturated,
                  input ready);
  modport sink   (input valid, src_gradient, src_column, row_done, tensor_done, saturated,
                  output ready);
endinterface
`default_nettype wire

// ===== src/ugbs_position.sv =====
`default_nettype none
module ugbs_position
  import ugbs_pkg::*;
#(
  parameter int MAX_SRC_WIDTH = DEF_MAX_SRC_WIDTH,
  parameter int MAX_SCALE     = DEF_MAX_SCALE
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    step,
  input  wire logic [$clog2(MAX_SCALE+1)-1:0]          s_lim,
  input  wire logic [$clog2(MAX_SRC_WIDTH+1)-1:0]      w_lim,
  input  wire logic [HEIGHT_REG_BITS-1:0]              h_lim,
  input  wire logic [CHAN_REG_BITS-1:0]                c_lim,
  input  wire logic [BATCH_REG_BITS-1:0]               n_lim,
  output logic [(MAX_SRC_WIDTH > 1 ? $clog2(MAX_SRC_WIDTH) : 1)-1:0] col,
  output pos_flags_t                                   flags
);

  localparam int SW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int CW = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;

  logic [SW-1:0]         sub_col_r, sub_col_nxt;
  logic [SW-1:0]         sub_row_r, sub_row_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [ROW_BITS-1:0]   row_r, row_nxt;
  logic [CHAN_BITS-1:0]  chan_r, chan_nxt;
  logic [BATCH_BITS-1:0] batch_r, batch_nxt;

  logic sc_wrap, col_wrap, sr_wrap, row_wrap, chan_wrap, batch_wrap;

  assign sc_wrap    = (32'(sub_col_r) + 32'd1) >= 32'(s_lim);
  assign sr_wrap    = (32'(sub_row_r) + 32'd1) >= 32'(s_lim);
  assign col_wrap   = (32'(col_r) + 32'd1) >= 32'(w_lim);
  assign row_wrap   = (32'(row_r) + 32'd1) >= 32'(h_lim);
  assign chan_wrap  = (32'(chan_r) + 32'd1) >= 32'(c_lim);
  assign batch_wrap = (32'(batch_r) + 32'd1) >= 32'(n_lim);

  assign col               = col_r;
  assign flags.first       = (sub_row_r == '0) && (sub_col_r == '0);
  assign flags.last        = sr_wrap && sc_wrap;
  assign flags.row_done    = col_wrap;
  assign flags.tensor_done = col_wrap && row_wrap && chan_wrap && batch_wrap;

  // Carry chain: sub column, column, sub row, row, channel, batch
  always_comb begin
    sub_col_nxt = sub_col_r;
    sub_row_nxt = sub_row_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    chan_nxt    = chan_r;
    batch_nxt   = batch_r;
    if (step) begin
      if (!sc_wrap) begin
        sub_col_nxt = sub_col_r + SW'(1);
      end else begin
        sub_col_nxt = '0;
        if (!col_wrap) begin
          col_nxt = col_r + CW'(1);
        end else begin
          col_nxt = '0;
          if (!sr_wrap) begin
            sub_row_nxt = sub_row_r + SW'(1);
          end else begin
            sub_row_nxt = '0;
            if (!row_wrap) begin
              row_nxt = row_r + ROW_BITS'(1);
            end else begin
              row_nxt = '0;
              if (!chan_wrap) begin
                chan_nxt = chan_r + CHAN_BITS'(1);
              end else begin
                chan_nxt  = '0;
                batch_nxt = batch_wrap ? '0 : batch_r + BATCH_BITS'(1);
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_col_r <= '0;
      sub_row_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
      chan_r    <= '0;
      batch_r   <= '0;
    end else begin
      sub_col_r <= sub_col_nxt;
      sub_row_r <= sub_row_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      chan_r    <= chan_nxt;
      batch_r   <= batch_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/upsample_gradient_block_sum_top.sv =====
`default_nettype none
`include "upsample_gradient_block_sum_top_defines.svh"
// Nearest-neighbor upsample backward pass. Output-gradient words stream in raster
// order at one word per cycle; each is folded into a per-source-column accumulator
// held in a single RAM (one write, one registered read per cycle). The word that
// closes a scale-by-scale block returns prior gradient plus block sum, saturated,
// via the s1 and output registers. The read-modify-write of that RAM sets the
// pace: one access per word, with the write of the word in flight forwarded to the
// word behind it when both hit the same column. Throughput is one word per cycle
// while the result side keeps up; an output register lets a new word in while a
// result waits. Accumulators need no clearing after reset: each block loads its
// accumulator on its first element. Program the registers only while the block is
// idle; zero in a register acts as one and oversized values are capped.
module upsample_gradient_block_sum_top
  import ugbs_pkg::*;
#(
  parameter int MAX_SRC_WIDTH = DEF_MAX_SRC_WIDTH,
  parameter int MAX_SCALE     = DEF_MAX_SCALE,
  parameter int GRAD_WIDTH    = DEF_GRAD_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  ugbs_in_if.sink                       in_ch,
  ugbs_out_if.source                    out_ch,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic      [CFG_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  localparam int ACC_BITS = GRAD_WIDTH + ACC_HEADROOM;
  localparam int CW       = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
  localparam int SLW      = $clog2(MAX_SCALE + 1);
  localparam int WLW      = $clog2(MAX_SRC_WIDTH + 1);
  localparam logic signed [ACC_BITS:0] GMAX =
    (ACC_BITS+1)'((64'sd1 <<< (GRAD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_BITS:0] GMIN = -GMAX - (ACC_BITS+1)'(1);

  // Configuration registers
  logic [SCALE_REG_BITS-1:0]  scale_r;
  logic [WIDTH_REG_BITS-1:0]  width_r;
  logic [HEIGHT_REG_BITS-1:0] height_r;
  logic [CHAN_REG_BITS-1:0]   chan_r;
  logic [BATCH_REG_BITS-1:0]  batch_r;
  logic                       cfg_wr;
  reg_idx_t                   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RESET;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      chan_r   <= CHAN_RESET;
      batch_r  <= BATCH_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SCALE:  scale_r  <= pwdata[SCALE_REG_BITS-1:0];
        REG_WIDTH:  width_r  <= pwdata[WIDTH_REG_BITS-1:0];
        REG_HEIGHT: height_r <= pwdata[HEIGHT_REG_BITS-1:0];
        REG_CHAN:   chan_r   <= pwdata[CHAN_REG_BITS-1:0];
        REG_BATCH:  batch_r  <= pwdata[BATCH_REG_BITS-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SCALE:  prdata = CFG_DATA_BITS'(scale_r);
      REG_WIDTH:  prdata = CFG_DATA_BITS'(width_r);
      REG_HEIGHT: prdata = CFG_DATA_BITS'(height_r);
      REG_CHAN:   prdata = CFG_DATA_BITS'(chan_r);
      REG_BATCH:  prdata = CFG_DATA_BITS'(batch_r);
      default:    prdata = '0;
    endcase
  end

  // Effective limits
  logic [SLW-1:0]             s_lim;
  logic [WLW-1:0]             w_lim;
  logic [HEIGHT_REG_BITS-1:0] h_lim;
  logic [CHAN_REG_BITS-1:0]   c_lim;
  logic [BATCH_REG_BITS-1:0]  n_lim;

  assign s_lim = SLW'(clamp_limit(32'(scale_r), 32'(MAX_SCALE)));
  assign w_lim = WLW'(clamp_limit(32'(width_r), 32'(MAX_SRC_WIDTH)));
  assign h_lim = HEIGHT_REG_BITS'(clamp_limit(32'(height_r), 32'(MAX_SRC_HEIGHT)));
  assign c_lim = CHAN_REG_BITS'(clamp_limit(32'(chan_r), 32'(MAX_CHANNELS)));
  assign n_lim = BATCH_REG_BITS'(clamp_limit(32'(batch_r), 32'(MAX_BATCH)));

  // Handshake and position
  logic       accept;
  logic       in_rdy;
  logic [CW-1:0] pos_col;
  pos_flags_t pos_flags;

  assign accept      = in_ch.valid && in_rdy;
  assign in_ch.ready = in_rdy;

  ugbs_position #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SCALE     (MAX_SCALE)
  ) u_position (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .s_lim (s_lim),
    .w_lim (w_lim),
    .h_lim (h_lim),
    .c_lim (c_lim),
    .n_lim (n_lim),
    .col   (pos_col),
    .flags (pos_flags)
  );

  // Accumulate stage
  logic                         s1_v_r;
  pos_flags_t                   s1_flags_r;
  logic [CW-1:0]                s1_col_r;
  logic signed [GRAD_WIDTH-1:0] s1_g_r;
  logic signed [GRAD_WIDTH-1:0] s1_prior_r;
  logic                         hit_r;
  logic signed [ACC_BITS-1:0]   fwd_acc_r;
  logic signed [ACC_BITS-1:0]   rd_data_r;
  logic signed [ACC_BITS-1:0]   acc_mem [MAX_SRC_WIDTH];

  logic                         s1_adv;
  logic                         s1_wr;
  logic                         out_load;
  logic signed [ACC_BITS-1:0]   acc_base;
  logic signed [ACC_BITS-1:0]   acc;
  logic signed [ACC_BITS:0]     sum;
  logic                         sat_hi;
  logic                         sat_lo;

  logic                         out_v_r;

  // Hold the block-closing word while the output register is full and not taken
  assign s1_adv   = s1_v_r && (!s1_flags_r.last || !out_v_r || out_ch.ready);
  assign in_rdy   = !s1_v_r || s1_adv;
  assign s1_wr    = s1_adv;
  assign out_load = s1_adv && s1_flags_r.last;

  assign acc_base = hit_r ? fwd_acc_r : rd_data_r;
  assign acc      = s1_flags_r.first ? ACC_BITS'(s1_g_r) : acc_base + ACC_BITS'(s1_g_r);
  assign sum      = (ACC_BITS+1)'(s1_prior_r) + (ACC_BITS+1)'(acc);
  assign sat_hi   = sum > GMAX;
  assign sat_lo   = sum < GMIN;

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      acc_mem[s1_col_r] <= acc;
    end
    if (accept) begin
      rd_data_r <= acc_mem[pos_col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      hit_r  <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
      // The word ahead writes this column at the same edge as the read
      hit_r  <= s1_wr && (s1_col_r == pos_col);
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags_r <= pos_flags;
      s1_col_r   <= pos_col;
      s1_g_r     <= in_ch.dst_gradient;
      s1_prior_r <= in_ch.prior_src_gradient;
      fwd_acc_r  <= acc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (sat_hi) begin
        out_ch.src_gradient <= GRAD_WIDTH'(GMAX);
      end else if (sat_lo) begin
        out_ch.src_gradient <= GRAD_WIDTH'(GMIN);
      end else begin
        out_ch.src_gradient <= GRAD_WIDTH'(sum);
      end
      out_ch.src_column  <= COL_OUT_BITS'(s1_col_r);
      out_ch.row_done    <= s1_flags_r.row_done;
      out_ch.tensor_done <= s1_flags_r.tensor_done;
      out_ch.saturated   <= sat_hi || sat_lo;
    end
  end

  assign out_ch.valid = out_v_r;

  `UGBS_ASSERT_SAME(a_load_only_last, clk, rst_n, out_load, s1_v_r && s1_flags_r.last, "result loaded from a word that does not close a block")
  `UGBS_ASSERT_NEXT(a_fwd_same_col, clk, rst_n, accept && s1_wr && (s1_col_r == pos_col), hit_r && s1_v_r && (fwd_acc_r == $past(acc)), "forwarded accumulator missing for same column")
  `UGBS_ASSERT_SAME(a_stall_cause, clk, rst_n, !in_rdy, s1_v_r && s1_flags_r.last && out_v_r && !out_ch.ready, "input stalled without a blocked result")

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ugbs_pkg::*;

  localparam logic signed [31:0] GRAD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] GRAD_MIN = 32'sh8000_0000;
  localparam logic signed [39:0] SUM_HI = 40'sd2147483647;
  localparam logic signed [39:0] SUM_LO = -40'sd2147483648;

  typedef struct {
    logic signed [31:0] grad;
    logic [8:0]         col;
    logic               row_end;
    logic               tensor_end;
    logic               sat;
  } block_result_t;

  logic clk;
  logic rst_n;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  ugbs_in_if  in_bus ();
  ugbs_out_if out_bus ();

  upsample_gradient_block_sum_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready)
  );

  // Shadow of the block: registers, position counters and column accumulators
  logic [SCALE_REG_BITS-1:0]  scale_cfg  = SCALE_RESET;
  logic [WIDTH_REG_BITS-1:0]  width_cfg  = WIDTH_RESET;
  logic [HEIGHT_REG_BITS-1:0] height_cfg = HEIGHT_RESET;
  logic [CHAN_REG_BITS-1:0]   chan_cfg   = CHAN_RESET;
  logic [BATCH_REG_BITS-1:0]  batch_cfg  = BATCH_RESET;

  int sub_col, src_col, sub_row, src_row, chan_idx, batch_idx;
  logic signed [37:0] col_acc [DEF_MAX_SRC_WIDTH];

  block_result_t pending_blocks[$];

  bit idle_en;
  int errors;
  int words_sent;
  int results_seen;
  int sat_seen;
  int shapes_run;

  int   stall_left = 0;
  logic sink_ready = 1'b0;

  assign out_bus.ready = sink_ready;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int lim(input int raw, input int hi);
    if (raw == 0) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // Advance one position counter; report a wrap so it carries into the next
  function automatic bit bump(inout int ctr, input int top);
    if (ctr + 1 >= top) begin
      ctr = 0;
      return 1'b1;
    end
    ctr++;
    return 1'b0;
  endfunction

  function automatic int tensor_words(input int s, input int w, input int h,
                                      input int c, input int n);
    int sl;
    sl = lim(s, DEF_MAX_SCALE);
    return sl * sl * lim(w, DEF_MAX_SRC_WIDTH) * lim(h, MAX_SRC_HEIGHT) *
           lim(c, MAX_CHANNELS) * lim(n, MAX_BATCH);
  endfunction

  function automatic void fold_word(input logic signed [31:0] dg,
                                    input logic signed [31:0] prior);
    int s, w, h, c, n;
    logic signed [37:0] acc;
    logic signed [39:0] total;
    block_result_t r;
    s = lim(int'(scale_cfg), DEF_MAX_SCALE);
    w = lim(int'(width_cfg), DEF_MAX_SRC_WIDTH);
    h = lim(int'(height_cfg), MAX_SRC_HEIGHT);
    c = lim(int'(chan_cfg), MAX_CHANNELS);
    n = lim(int'(batch_cfg), MAX_BATCH);
    // first element of a block loads the accumulator
    if (sub_row == 0 && sub_col == 0) acc = 38'(dg);
    else acc = col_acc[src_col] + 38'(dg);
    col_acc[src_col] = acc;
    if (sub_row + 1 >= s && sub_col + 1 >= s) begin
      total = 40'(prior) + 40'(acc);
      r.sat = 1'b0;
      if (total > SUM_HI) begin
        total = SUM_HI;
        r.sat = 1'b1;
      end
      if (total < SUM_LO) begin
        total = SUM_LO;
        r.sat = 1'b1;
      end
      r.grad = total[31:0];
      r.col = src_col[8:0];
      r.row_end = (src_col + 1 >= w);
      r.tensor_end = r.row_end && (src_row + 1 >= h) && (chan_idx + 1 >= c) &&
                     (batch_idx + 1 >= n);
      pending_blocks.push_back(r);
    end
    if (bump(sub_col, s))
      if (bump(src_col, w))
        if (bump(sub_row, s))
          if (bump(src_row, h))
            if (bump(chan_idx, c))
              void'(bump(batch_idx, n));
  endfunction

  function automatic logic signed [31:0] pick_grad();
    case ($urandom_range(0, 7))
      0: return GRAD_MAX;
      1: return GRAD_MIN;
      2: return $urandom_range(0, 511) - 256;
      default: return $urandom;
    endcase
  endfunction

  function automatic void report(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    block_result_t exp_r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_blocks.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %0h col %0d",
                 $time, out_bus.src_gradient, out_bus.src_column);
      end else begin
        exp_r = pending_blocks.pop_front();
        results_seen++;
        if (exp_r.sat) sat_seen++;
        report("src_gradient", exp_r.grad, out_bus.src_gradient);
        report("src_column", 32'(exp_r.col), 32'(out_bus.src_column));
        report("row_done", 32'(exp_r.row_end), 32'(out_bus.row_done));
        report("tensor_done", 32'(exp_r.tensor_end), 32'(out_bus.tensor_done));
        report("saturated", 32'(exp_r.sat), 32'(out_bus.saturated));
      end
    end
  end

  task automatic send_word(input logic signed [31:0] dg, input logic signed [31:0] prior);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_bus.valid              <= 1'b1;
    in_bus.dst_gradient       <= dg;
    in_bus.prior_src_gradient <= prior;
    do @(posedge clk); while (!in_bus.ready);
    fold_word(dg, prior);
    words_sent++;
  endtask

  // Drop valid, drain every pending result, then let the pipeline settle
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] word;
    word = val;
    // bits above the field are don't-care; fill them with noise
    case (idx)
      REG_SCALE: begin
        word[31:SCALE_REG_BITS] = (32-SCALE_REG_BITS)'($urandom);
        scale_cfg = val[SCALE_REG_BITS-1:0];
      end
      REG_WIDTH: begin
        word[31:WIDTH_REG_BITS] = (32-WIDTH_REG_BITS)'($urandom);
        width_cfg = val[WIDTH_REG_BITS-1:0];
      end
      REG_HEIGHT: begin
        word[31:HEIGHT_REG_BITS] = (32-HEIGHT_REG_BITS)'($urandom);
        height_cfg = val[HEIGHT_REG_BITS-1:0];
      end
      REG_CHAN: begin
        word[31:CHAN_REG_BITS] = (32-CHAN_REG_BITS)'($urandom);
        chan_cfg = val[CHAN_REG_BITS-1:0];
      end
      REG_BATCH: begin
        word[31:BATCH_REG_BITS] = (32-BATCH_REG_BITS)'($urandom);
        batch_cfg = val[BATCH_REG_BITS-1:0];
      end
      default: ;
    endcase
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_BITS'(idx) << 2;
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic configure(input logic [31:0] s, input logic [31:0] w, input logic [31:0] h,
                           input logic [31:0] c, input logic [31:0] n);
    wait_idle();
    cfg_write(REG_SCALE, s);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_CHAN, c);
    cfg_write(REG_BATCH, n);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    shapes_run++;
  endtask

  // One full tensor of random words; optionally hold mid-tensor until drained
  task automatic send_tensor(input int hold_at);
    int total;
    total = tensor_words(int'(scale_cfg), int'(width_cfg), int'(height_cfg),
                         int'(chan_cfg), int'(batch_cfg));
    for (int i = 0; i < total; i++) begin
      if (i == hold_at) begin
        in_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_blocks.size() != 0);
      end
      send_word(pick_grad(), pick_grad());
    end
  endtask

  // 2x2 blocks, two columns: column 0 saturates high, column 1 low
  task automatic test_block_saturation();
    logic signed [31:0] v;
    configure(2, 2, 1, 1, 1);
    for (int i = 0; i < 8; i++) begin
      v = ((i >> 1) & 1) ? GRAD_MIN : GRAD_MAX;
      send_word(v, v);
    end
    send_tensor(-1);
  endtask

  // Zero in every register acts as one: each word closes its own block
  task automatic test_unit_scale();
    logic signed [31:0] dg_list [10] = '{GRAD_MAX, GRAD_MIN, GRAD_MAX, GRAD_MIN, 0,
                                         -1, 1, -1, 32'sh0001_0000, GRAD_MAX};
    logic signed [31:0] pr_list [10] = '{GRAD_MAX, GRAD_MIN, 0, 0, 0,
                                         1, GRAD_MAX, GRAD_MIN, -32'sh0001_0000, GRAD_MIN};
    configure(0, 0, 0, 0, 0);
    for (int i = 0; i < 10; i++) send_word(dg_list[i], pr_list[i]);
  endtask

  task automatic test_register_limits();
    configure(4'hF, 0, 0, 0, 0);
    send_tensor(-1);
    configure(1, 1, 1, 1, 7'h7F);
    send_tensor(-1);
  endtask

  task automatic draw_shape();
    logic [31:0] s, w, h, c, n;
    do begin
      s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
      w = $urandom_range(0, 9);
      h = $urandom_range(0, 3);
      c = $urandom_range(0, 3);
      n = $urandom_range(0, 2);
    end while (tensor_words(s, w, h, c, n) > 160);
    configure(s, w, h, c, n);
  endtask

  task automatic test_random_shapes();
    int start;
    bit first;
    start = words_sent;
    first = 1'b1;
    while (words_sent - start < 200) begin
      idle_en = ($urandom_range(0, 3) != 0);
      draw_shape();
      repeat ($urandom_range(1, 2)) begin
        send_tensor(first ? tensor_words(int'(scale_cfg), int'(width_cfg),
                                         int'(height_cfg), int'(chan_cfg),
                                         int'(batch_cfg)) / 2 : -1);
        first = 1'b0;
      end
    end
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    repeat (4) begin
      draw_shape();
      send_tensor(-1);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    idle_en     = 1'b1;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    in_bus.valid              <= 1'b0;
    in_bus.dst_gradient       <= '0;
    in_bus.prior_src_gradient <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_block_saturation();
    test_unit_scale();
    test_register_limits();
    test_random_shapes();
    test_back_to_back();

    in_bus.valid <= 1'b0;
    for (int k = 0; k < 2000 && pending_blocks.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_blocks.size() != 0) begin
      errors++;
      $display("%0t: %0d block results never arrived, expected %0d, actual 0",
               $time, pending_blocks.size(), pending_blocks.size());
    end

    $display("Streamed %0d gradient words over %0d register shapes (1x1 to 8x8 blocks,",
             words_sent, shapes_run);
    $display("zero and oversized registers), checked %0d block sums, %0d of them saturated.",
             results_seen, sat_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ugbs_pkg.sv
src/ugbs_if.sv
src/ugbs_position.sv
src/upsample_gradient_block_sum_top.sv
dv/tb.sv
